[hdl/dcpa_pkg.sv]
// ----------------------------------------------------------------------------
// dcpa_pkg - shared types and constants for the dual channel pressure alarm
// Register indexes, counter limits and the structs passed between the lanes
// and the merge stage.
// ----------------------------------------------------------------------------
package dcpa_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_DUAL_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CH1_THRESHOLD = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CH2_THRESHOLD = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RECOVERY_MIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ALARM_TICKS   = 3'd4;

  localparam logic [SampleW-1:0] RUN_MAX         = 16'hFFFF;
  localparam logic [SampleW-1:0] ALARM_TICKS_RST = 16'd60000;

  // Merge stage to lanes: advance the counter, and force it to zero
  typedef struct packed {
    logic step;
    logic clear;
  } lane_ctl_t;

  // Lane to merge stage: candidate run length for this transaction
  typedef struct packed {
    logic [SampleW-1:0] cand;
    logic               nonzero;
  } lane_stat_t;

  // Alarm flag pair
  typedef struct packed {
    logic one;
    logic two;
  } flags_t;

endpackage

[hdl/dual_channel_pressure_alarm.sv]
// ----------------------------------------------------------------------------
// dual_channel_pressure_alarm - two channel low pressure alarm
// Configuration registers, two counter lanes, the merge stage and a
// two-entry output buffer.
// ----------------------------------------------------------------------------
// Output: each result is registered into the output buffer when its input is taken.
// Throughput: one transaction per cycle; the two-entry output buffer lets
//   input be taken while a result waits, stalling only when both are full.
// Reset: synchronous, active low; counters and flags clear, alarm_ticks
//   returns to 60000, other registers to zero, output buffer empties.
module dual_channel_pressure_alarm
  import dcpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SampleW-1:0] in_pressure_one,
  input  logic [SampleW-1:0] in_pressure_two,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_alarm_one,
  output logic               out_alarm_two,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [SampleW-1:0] cfg_data
);

  logic               dual_mode_r;
  logic [SampleW-1:0] ch1_threshold_r;
  logic [SampleW-1:0] ch2_threshold_r;
  logic [SampleW-1:0] recovery_min_r;
  logic [SampleW-1:0] alarm_ticks_r;

  logic       push;
  logic       pop;
  lane_ctl_t  ctl;
  lane_stat_t stat_one;
  lane_stat_t stat_two;
  flags_t     flags_nxt;

  flags_t     e0_r, e0_nxt;
  flags_t     e1_r, e1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dual_mode_r     <= 1'b0;
      ch1_threshold_r <= '0;
      ch2_threshold_r <= '0;
      recovery_min_r  <= '0;
      alarm_ticks_r   <= ALARM_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DUAL_MODE:     dual_mode_r     <= cfg_data[0];
        REG_CH1_THRESHOLD: ch1_threshold_r <= cfg_data;
        REG_CH2_THRESHOLD: ch2_threshold_r <= cfg_data;
        REG_RECOVERY_MIN:  recovery_min_r  <= cfg_data;
        REG_ALARM_TICKS:   alarm_ticks_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  // Lanes
  dcpa_lane u_lane_one (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample    (in_pressure_one),
    .threshold (ch1_threshold_r),
    .ctl       (ctl),
    .stat      (stat_one)
  );

  dcpa_lane u_lane_two (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample    (in_pressure_two),
    .threshold (ch2_threshold_r),
    .ctl       (ctl),
    .stat      (stat_two)
  );

  // Merge stage
  dcpa_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (push),
    .dual_mode    (dual_mode_r),
    .recovery_min (recovery_min_r),
    .alarm_ticks  (alarm_ticks_r),
    .sample_one   (in_pressure_one),
    .sample_two   (in_pressure_two),
    .stat_one     (stat_one),
    .stat_two     (stat_two),
    .ctl          (ctl),
    .flags_nxt    (flags_nxt)
  );

  // Two-entry output buffer, head in e0
  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b11: begin
        e0_nxt = flags_nxt;
      end
      2'b01: begin
        e0_nxt  = e1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b10: begin
        if (cnt_r == 2'd0) begin
          e0_nxt = flags_nxt;
        end else begin
          e1_nxt = flags_nxt;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign out_alarm_one = e0_r.one;
  assign out_alarm_two = e0_r.two;

  // Assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a waiting result");

  a_single_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !dual_mode_r) |-> (!flags_nxt.one && !flags_nxt.two))
    else $error("alarm raised with dual mode off");

  a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !push |-> !ctl.step)
    else $error("counters stepped without an input transaction");

endmodule

[hdl/dcpa_lane.sv]
// ----------------------------------------------------------------------------
// dcpa_lane - one channel's low pressure run counter
// Works out the saturating candidate run for the sample and holds the
// counter, which the merge stage advances or clears.
// ----------------------------------------------------------------------------
module dcpa_lane
  import dcpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SampleW-1:0] sample,
  input  logic [SampleW-1:0] threshold,
  input  lane_ctl_t          ctl,
  output lane_stat_t         stat
);

  logic [SampleW-1:0] run_r;
  logic [SampleW-1:0] run_nxt;

  // Candidate: count up while below threshold, saturating at the top
  always_comb begin
    if (sample < threshold) begin
      stat.cand = (run_r == RUN_MAX) ? RUN_MAX : run_r + 1'b1;
    end else begin
      stat.cand = '0;
    end
    stat.nonzero = (stat.cand != '0);
  end

  // Counter update
  always_comb begin
    run_nxt = run_r;
    if (ctl.step) begin
      run_nxt = ctl.clear ? '0 : stat.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

endmodule

[hdl/dcpa_merge.sv]
// ----------------------------------------------------------------------------
// dcpa_merge - combines the two lanes and keeps the alarm flags
// Detects a common-cause drop, raises alarms on run length and clears
// them on recovery.
// ----------------------------------------------------------------------------
module dcpa_merge
  import dcpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               dual_mode,
  input  logic [SampleW-1:0] recovery_min,
  input  logic [SampleW-1:0] alarm_ticks,
  input  logic [SampleW-1:0] sample_one,
  input  logic [SampleW-1:0] sample_two,
  input  lane_stat_t         stat_one,
  input  lane_stat_t         stat_two,
  output lane_ctl_t          ctl,
  output flags_t             flags_nxt
);

  flags_t             flags_r;
  logic               clear;
  logic [SampleW-1:0] fin_one;
  logic [SampleW-1:0] fin_two;

  // Drop on both channels together restarts both runs
  assign clear   = stat_one.nonzero && stat_two.nonzero;
  assign fin_one = clear ? '0 : stat_one.cand;
  assign fin_two = clear ? '0 : stat_two.cand;

  // Flag update and lane control
  always_comb begin
    flags_nxt = flags_r;
    ctl.step  = 1'b0;
    ctl.clear = clear;
    priority if (!dual_mode) begin
      flags_nxt = '0;
    end else if (!flags_r.one && !flags_r.two) begin
      ctl.step = accept;
      if (fin_one >= alarm_ticks) flags_nxt.one = 1'b1;
      if (fin_two >= alarm_ticks) flags_nxt.two = 1'b1;
    end else if (flags_r.one) begin
      if (sample_one > recovery_min) flags_nxt.one = 1'b0;
    end else begin
      if (sample_two > recovery_min) flags_nxt.two = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (accept) begin
      flags_r <= flags_nxt;
    end
  end

endmodule
